// ===== sv/dip_pkg.sv =====
// shared types, character codes and helpers for the delimited integer parser
package dip_pkg;

   // default saturation limit of the per-line number count
   localparam int unsigned MAX_COUNT_DEFAULT = 65535;

   // result queue depth, a power of two so the pointers wrap by themselves
   localparam int unsigned QUEUE_DEPTH = 4;

   // character codes
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_PCT   = 8'h25;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_SEMI  = 8'h3B;

   // clamp limits of the signed result
   localparam logic [31:0] POS_LIMIT = 32'h7FFF_FFFF;
   localparam logic [31:0] NEG_LIMIT = 32'h8000_0000;

   // result kinds
   localparam logic KIND_NUMBER  = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef enum logic [1:0] {
      PHASE_BETWEEN,
      PHASE_SIGN,
      PHASE_DIGITS,
      PHASE_BAD
   } phase_type;

   typedef struct packed {
      logic        saturated;
      logic [31:0] value;
   } number_type;

   typedef struct packed {
      logic        kind;
      logic [31:0] value;
      logic        saturated;
      logic [15:0] count;
   } result_type;

   // results raised by one item: an optional number, then an optional summary
   typedef struct packed {
      logic       num_valid;
      logic       sum_valid;
      result_type num;
      result_type sum;
   } push_type;

   // signed conversion of a magnitude with clamping to the 32-bit range
   function automatic number_type finish_token(input logic neg, input logic [31:0] mag,
                                               input logic clamped);
      number_type r;
      r.saturated = clamped;
      if (neg) begin
         if (mag > NEG_LIMIT) begin
            r.saturated = 1'b1;
            r.value     = NEG_LIMIT;
         end else begin
            r.value = 32'd0 - mag;
         end
      end else begin
         if (mag > POS_LIMIT) begin
            r.saturated = 1'b1;
            r.value     = POS_LIMIT;
         end else begin
            r.value = mag;
         end
      end
      return r;
   endfunction

endpackage

// ===== sv/dip_token_core.sv =====
// token state and per-byte decode of the delimited integer parser
module dip_token_core #(
   parameter int unsigned MAX_COUNT = dip_pkg::MAX_COUNT_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        character,
   input  logic              last_in_line,
   output dip_pkg::push_type push
);
   import dip_pkg::*;

   localparam int unsigned COUNT_W = $clog2(MAX_COUNT + 1);

   phase_type          phase_ff, phase_in;
   logic               neg_ff, neg_in;
   logic [31:0]        mag_ff, mag_in;
   logic               clamp_ff, clamp_in;
   logic [31:0]        held_value_ff, held_value_in;
   logic               held_clamp_ff, held_clamp_in;
   logic               held_valid_ff, held_valid_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   logic               is_space, is_delim, is_pct, is_digit, is_sign;
   logic [31:0]        base_mag;
   logic [35:0]        product;
   number_type         fin;
   logic               emit_num;
   logic [COUNT_W-1:0] count_bump;

   // character classes
   always_comb begin
      is_space = (character == CHAR_SPACE) || (character >= CHAR_TAB && character <= CHAR_CR);
      is_delim = is_space || (character == CHAR_SEMI);
      is_pct   = character == CHAR_PCT;
      is_digit = (character >= CHAR_ZERO) && (character <= CHAR_NINE);
      is_sign  = (character == CHAR_PLUS) || (character == CHAR_MINUS);
   end

   // token phase
   always_comb begin
      phase_in = phase_ff;
      if (is_delim) begin
         phase_in = PHASE_BETWEEN;
      end else if (is_pct) begin
         phase_in = PHASE_BAD;
      end else if (is_digit) begin
         if (phase_ff != PHASE_BAD) begin
            phase_in = PHASE_DIGITS;
         end
      end else if (is_sign && phase_ff == PHASE_BETWEEN) begin
         phase_in = PHASE_SIGN;
      end else begin
         phase_in = PHASE_BAD;
      end
      if (last_in_line) begin
         phase_in = PHASE_BETWEEN;
      end
   end

   // magnitude accumulation, held number, count and results
   always_comb begin
      base_mag = (phase_ff == PHASE_BETWEEN) ? 32'd0 : mag_ff;
      product  = ({4'd0, base_mag} << 3) + ({4'd0, base_mag} << 1) + {32'd0, character[3:0]};

      neg_in   = neg_ff;
      mag_in   = mag_ff;
      clamp_in = clamp_ff;
      if (is_digit && phase_ff != PHASE_BAD) begin
         if (phase_ff == PHASE_BETWEEN) begin
            neg_in   = 1'b0;
            clamp_in = 1'b0;
         end
         if (product[35:32] != 4'd0) begin
            mag_in   = 32'hFFFF_FFFF;
            clamp_in = 1'b1;
         end else begin
            mag_in = product[31:0];
         end
      end else if (!is_delim && !is_pct && is_sign && phase_ff == PHASE_BETWEEN) begin
         neg_in   = character == CHAR_MINUS;
         mag_in   = 32'd0;
         clamp_in = 1'b0;
      end

      // delimiters and percent leave the magnitude alone, so one conversion serves all
      fin = finish_token(neg_in, mag_in, clamp_in);

      held_value_in = held_value_ff;
      held_clamp_in = held_clamp_ff;
      held_valid_in = held_valid_ff && (is_delim || is_pct);
      if (is_pct && phase_ff == PHASE_DIGITS) begin
         held_value_in = fin.value;
         held_clamp_in = fin.saturated;
         held_valid_in = 1'b1;
      end

      // a number leaves on a delimiter, or at line end from the open token or the held one
      emit_num = (is_delim && phase_ff == PHASE_DIGITS)
                 || (last_in_line && is_digit && phase_ff != PHASE_BAD)
                 || (last_in_line && held_valid_in);

      count_bump = count_ff;
      if (emit_num && count_ff < COUNT_W'(MAX_COUNT)) begin
         count_bump = count_ff + COUNT_W'(1);
      end
      count_in = last_in_line ? '0 : count_bump;

      push.num_valid     = accept && emit_num;
      push.sum_valid     = accept && last_in_line;
      push.num.kind      = KIND_NUMBER;
      push.num.value     = fin.value;
      push.num.saturated = fin.saturated;
      if (!(is_delim && phase_ff == PHASE_DIGITS)
          && !(is_digit && phase_ff != PHASE_BAD)) begin
         push.num.value     = held_value_in;
         push.num.saturated = held_clamp_in;
      end
      push.num.count     = 16'(count_bump);
      push.sum.kind      = KIND_SUMMARY;
      push.sum.value     = 32'd0;
      push.sum.saturated = 1'b0;
      push.sum.count     = 16'(count_bump);
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PHASE_BETWEEN;
         held_valid_ff <= 1'b0;
         count_ff      <= '0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         held_valid_ff <= held_valid_in && !last_in_line;
         count_ff      <= count_in;
      end
   end

   // token payload
   always_ff @(posedge clock) begin
      if (accept) begin
         neg_ff        <= neg_in;
         mag_ff        <= mag_in;
         clamp_ff      <= clamp_in;
         held_value_ff <= held_value_in;
         held_clamp_ff <= held_clamp_in;
      end
   end

endmodule

// ===== sv/dip_result_queue.sv =====
// small result queue taking up to two results per cycle and giving one
module dip_result_queue (
   input  logic                clock,
   input  logic                reset,
   input  dip_pkg::push_type   push,
   output logic                has_room,
   output logic                head_valid,
   input  logic                head_ready,
   output dip_pkg::result_type head
);
   import dip_pkg::*;

   localparam int unsigned PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int unsigned FILL_W = $clog2(QUEUE_DEPTH + 1);

   result_type        entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [PTR_W-1:0]  wr_second;
   logic [1:0]        push_count;
   logic              pop;

   // pointer and fill arithmetic
   always_comb begin
      push_count = {1'b0, push.num_valid} + {1'b0, push.sum_valid};
      pop        = head_valid && head_ready;
      wr_second  = push.num_valid ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      wr_ptr_in  = wr_ptr_ff + PTR_W'(push_count);
      rd_ptr_in  = rd_ptr_ff + PTR_W'(pop);
      fill_in    = fill_ff + FILL_W'(push_count) - FILL_W'(pop);
   end

   // room for the two results an item may raise
   assign has_room   = fill_ff <= FILL_W'(QUEUE_DEPTH - 2);
   assign head_valid = fill_ff != '0;
   assign head       = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push.num_valid) begin
         entry_ff[wr_ptr_ff] <= push.num;
      end
      if (push.sum_valid) begin
         entry_ff[wr_second] <= push.sum;
      end
   end

endmodule

// ===== sv/delimited_integer_parser.sv =====
// Results: a result item enters the result queue when the input item that raises it is accepted.
// Throughput: one input item per cycle while the queue has room; the final byte of a line may raise a number
// and a summary, which leave one after the other on the one-item-per-cycle result port while rsp_tready is high.
// A four-entry result queue decouples the sides; input stalls when fewer than two free.
// Reset: synchronous, clears token phase, held number, line count and result queue.
module delimited_integer_parser #(
   parameter int unsigned MAX_COUNT = dip_pkg::MAX_COUNT_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] character
   input  logic        req_tlast,   // last_in_line
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [31:0] value, [32] saturated, [48:33] count, rest zero
   output logic [0:0]  rsp_tuser    // [0] kind
);
   import dip_pkg::*;

   push_type   push;
   result_type head;
   logic       accept;

   assign accept = req_tvalid && req_tready;

   // per-byte decode and token state
   dip_token_core #(
      .MAX_COUNT (MAX_COUNT)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .character    (req_tdata),
      .last_in_line (req_tlast),
      .push         (push)
   );

   // result queue
   dip_result_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .has_room   (req_tready),
      .head_valid (rsp_tvalid),
      .head_ready (rsp_tready),
      .head       (head)
   );

   // result packing
   assign rsp_tdata = {7'd0, head.count, head.saturated, head.value};
   assign rsp_tuser = head.kind;

endmodule

// ===== sv/dip_checker.sv =====
// port-level checks of the delimited integer parser, bound to the top level
module dip_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata,
   input logic [0:0]  rsp_tuser
);
   import dip_pkg::*;

   // a stalled result item holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result item changed");

   // no result item right after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result item offered after reset");

   // an empty result side never holds back the input
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with no result item waiting");

   // a summary carries zero value and no saturation
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] == KIND_SUMMARY |-> rsp_tdata[32:0] == 33'd0)
      else $error("summary item with value or saturation");

   // a saturated number sits on one of the clamp limits
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] == KIND_NUMBER && rsp_tdata[32]
      |-> rsp_tdata[31:0] == POS_LIMIT || rsp_tdata[31:0] == NEG_LIMIT)
      else $error("saturated number off the clamp limits");

endmodule

bind delimited_integer_parser dip_checker u_dip_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
